// ----- src/tick_task_scheduler_macros.svh -----
// Assertion macros shared by the scheduler RTL
`ifndef TICK_TASK_SCHEDULER_MACROS_SVH
`define TICK_TASK_SCHEDULER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define TTS_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define TTS_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) else $error(msg);

`endif

// ----- src/tts_pkg.sv -----
// Shared constants, opcodes and control structs of the tick task scheduler
package tts_pkg;

    localparam int TASK_COUNT = 8;
    localparam int TIMER_BITS = 16;
    localparam int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    localparam int OPCODE_W   = 2;
    localparam int IN_IDX_W   = 3;
    localparam int RELOAD_W   = 16;
    localparam int MASK_W     = 8;
    localparam int RUN_TASK_W = 3;
    localparam int SNAP_W     = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK     = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_ACTIVATE = 2'd2
    } t_opcode;

    // Countdown load request from the front end
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic [TIMER_BITS-1:0] value;
    } t_load;

    // One checked entry of the countdown walk
    typedef struct packed {
        logic             step;
        logic [IDX_W-1:0] idx;
        logic             expire;
        logic             last;
    } t_step;

endpackage

// ----- src/tts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data
module tts_ram #(
    parameter  int WIDTH  = 16,
    parameter  int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tts_walker.sv -----
// Countdown store and the read-modify-write walk over all task timers
module tts_walker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tts_pkg::t_load i_load,
    output tts_pkg::t_step o_step
);

    import tts_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

    logic                  r_active;
    logic [IDX_W-1:0]      r_issue;
    logic                  r_chk_valid;
    logic [IDX_W-1:0]      r_chk_idx;
    logic                  r_chk_last;
    logic [TASK_COUNT-1:0] r_live;
    logic [TASK_COUNT-1:0] n_live;

    logic [TIMER_BITS-1:0] w_rdata;
    logic [TIMER_BITS-1:0] w_cur;
    logic                  w_dec;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [TIMER_BITS-1:0] w_wdata;
    logic                  w_issue_last;

    tts_ram #(
        .WIDTH (TIMER_BITS),
        .DEPTH (TASK_COUNT)
    ) u_countdown (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_issue),
        .o_rdata (w_rdata)
    );

    assign w_issue_last = (r_issue == LAST_IDX);

    // An entry never loaded since reset reads as zero
    assign w_cur = r_live[r_chk_idx] ? w_rdata : '0;
    assign w_dec = r_chk_valid && (w_cur != '0);

    // Load and walk never overlap: loads come only while the walk is idle
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_chk_idx;
        w_wdata = w_cur - TIMER_BITS'(1);
        if (i_load.en) begin
            w_we    = 1'b1;
            w_waddr = i_load.idx;
            w_wdata = i_load.value;
        end else if (w_dec) begin
            w_we = 1'b1;
        end
    end

    always_comb begin
        n_live = r_live;
        if (i_load.en) begin
            n_live[i_load.idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_issue     <= '0;
            r_chk_valid <= 1'b0;
            r_chk_last  <= 1'b0;
            r_live      <= '0;
        end else begin
            r_live      <= n_live;
            r_chk_valid <= r_active;
            r_chk_last  <= r_active && w_issue_last;
            if (i_start) begin
                r_active <= 1'b1;
                r_issue  <= '0;
            end else if (r_active) begin
                // advance the read pointer, stop after the last task
                r_issue <= r_issue + IDX_W'(1);
                if (w_issue_last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_issue;
    end

    assign o_step.step   = r_chk_valid;
    assign o_step.idx    = r_chk_idx;
    assign o_step.expire = w_dec && (w_cur == TIMER_BITS'(1));
    assign o_step.last   = r_chk_last;

endmodule

// ----- src/tick_task_scheduler.sv -----
// Tick-driven cooperative task scheduler, top level.
// Tick word: the walk reads one countdown per cycle from the countdown RAM, then the
// result goes through the hold state to the output register. Complete and activate words
// go straight to the hold state. A new word is taken once the result is loaded.
// A word is taken while the previous result still waits in the output register.
// Synchronous active-low reset clears timers (through per-entry live bits) and ready bits.
`include "tick_task_scheduler_macros.svh"

module tick_task_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tts_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [tts_pkg::IN_IDX_W-1:0]   i_task_index,
    input  logic [tts_pkg::RELOAD_W-1:0]   i_reload_value,
    input  logic [tts_pkg::MASK_W-1:0]     i_activate_mask,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_run_valid,
    output logic [tts_pkg::RUN_TASK_W-1:0] o_run_task,
    output logic [tts_pkg::SNAP_W-1:0]     o_ready_snapshot
);

    import tts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [TASK_COUNT-1:0] r_ready;
    logic [TASK_COUNT-1:0] n_ready;
    logic                  r_found;
    logic                  n_found;
    logic [IDX_W-1:0]      r_task;
    logic [IDX_W-1:0]      n_task;

    logic                  r_out_valid;
    logic                  r_run_valid;
    logic [RUN_TASK_W-1:0] r_run_task;
    logic [SNAP_W-1:0]     r_snapshot;

    logic                  w_accept;
    logic                  w_start;
    logic                  w_out_load;
    t_load                 w_load;
    t_step                 w_step;

    tts_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_load  (w_load),
        .o_step  (w_step)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == S_HOLD) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state      = r_state;
        n_ready      = r_ready;
        n_found      = r_found;
        n_task       = r_task;
        w_start      = 1'b0;
        w_load.en    = 1'b0;
        w_load.idx   = IDX_W'(i_task_index);
        w_load.value = TIMER_BITS'(i_reload_value);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_found = 1'b0;
                    n_task  = '0;
                    n_state = S_HOLD;
                    case (t_opcode'(i_opcode))
                        OP_TICK: begin
                            w_start = 1'b1;
                            n_state = S_WALK;
                        end
                        OP_COMPLETE: begin
                            // drop a complete word for a task beyond the table
                            if (32'(i_task_index) < TASK_COUNT) begin
                                w_load.en           = 1'b1;
                                n_ready[w_load.idx] = 1'b0;
                            end
                        end
                        OP_ACTIVATE: begin
                            n_ready = r_ready | TASK_COUNT'(i_activate_mask);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_step.step) begin
                    if (w_step.expire) begin
                        n_ready[w_step.idx] = 1'b1;
                    end
                    // earlier tasks are final here, so the first hit is the winner
                    if (!r_found && (r_ready[w_step.idx] || w_step.expire)) begin
                        n_found = 1'b1;
                        n_task  = w_step.idx;
                    end
                    if (w_step.last) begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= '0;
            r_found     <= 1'b0;
            r_task      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_found <= n_found;
            r_task  <= n_task;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_run_valid <= r_found;
            r_run_task  <= RUN_TASK_W'(r_task);
            r_snapshot  <= SNAP_W'(r_ready);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_run_valid      = r_run_valid;
    assign o_run_task       = r_run_task;
    assign o_ready_snapshot = r_snapshot;

    `TTS_ASSERT_NOW(a_step_in_walk, w_step.step, r_state == S_WALK, "walk step outside walk")
    `TTS_ASSERT_NEXT(a_tick_walks, w_accept && (i_opcode == OP_TICK), r_state == S_WALK,
                     "tick word did not start a walk")
    `TTS_ASSERT_NEXT(a_walk_only_sets, r_state == S_WALK,
                     (r_ready & $past(r_ready)) == $past(r_ready), "walk cleared a ready bit")
    `TTS_ASSERT_NOW(a_found_is_ready, r_found && (r_state == S_HOLD), r_ready[r_task],
                    "reported task is not ready")

endmodule
